FILE: design/smf_pkg.sv
// Shared constants for the sliding median filter.
`default_nettype none

package smf_pkg;

    // Width of the window_size register.
    localparam int CFG_BITS = 4;

    // Width of a half-window value (window_size / 2).
    localparam int HALF_BITS = CFG_BITS - 1;

    // window_size after reset.
    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd3;

endpackage : smf_pkg

`default_nettype wire

FILE: design/sliding_median_filter.sv
// Sliding median filter over a waveform sample stream; odd window, else pass-through.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: sample_in; tlast: last_in
//  m_      | out | m_tvalid/m_tready  | tdata: sample_out; tuser: was_filtered;
//          |     |                    | tlast: last_out
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data: window_size (always ready)
//
// One word in and one word out per cycle in steady state while m_tready is high; the
// median of the window is formed combinationally from the sample taps by a rank
// comparison matrix. A word with tlast and an odd window of 2h+1 adds h flush words
// (all its words if the waveform has h or fewer), so s_tready is held low while the
// store is read out. Reset (aresetn, synchronous) clears the control and sets the
// window to 3; the sample taps are not cleared. m_tready low holds the result
// register and stalls the input once the pending word has nowhere to go.
`default_nettype none

module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  wire                                  s_tlast,   // last_in
    // result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    output logic                                 m_tuser,   // was_filtered
    output logic                                 m_tlast,   // last_out
    // configuration
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [CFG_BITS-1:0]                  cfg_data   // window_size
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IDXW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW         = $clog2(MAX_WINDOW + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WINDOW);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] window_reg [MAX_WINDOW];   // newest at 0
    logic [CW-1:0]        count_reg,   count_next;
    logic [HALF_BITS-1:0] half_reg,    half_next;
    logic                 filt_reg,    filt_next;
    logic [CFG_BITS-1:0]  ws_reg;

    // pending work read from the taps: one main word, then flush words
    logic                 main_reg,      main_next;
    logic                 main_med_reg,  main_med_next;
    logic [IDXW-1:0]      main_idx_reg,  main_idx_next;
    logic                 main_last_reg, main_last_next;
    logic [HALF_BITS-1:0] flush_reg,     flush_next;     // words left, next tap is flush-1

    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                 out_filt_reg;
    logic                 out_last_reg;
    logic                 m_valid_reg, m_valid_next;

    logic                 s_accept;
    logic                 advance;
    logic                 pend_any;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Median of the first 2h+1 taps by rank: tap i is the median when fewer
    // than h+1 taps are below it and more than h are at or below it.
    // ------------------------------------------------------------------
    logic [CW-1:0]                 lt_cnt [MAX_WINDOW];
    logic [CW-1:0]                 le_cnt [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] median;
    logic [CFG_BITS-1:0]           win_len;

    assign win_len = {half_reg, 1'b1};

    always_comb begin
        logic found;
        found  = 1'b0;
        median = window_reg[0];
        for (int i = 0; i < MAX_WINDOW; i++) begin
            lt_cnt[i] = '0;
            le_cnt[i] = '0;
            for (int j = 0; j < MAX_WINDOW; j++) begin
                if (j < int'(win_len)) begin
                    if (window_reg[j] < window_reg[i]) begin
                        lt_cnt[i] = lt_cnt[i] + 1'b1;
                    end
                    if (window_reg[j] <= window_reg[i]) begin
                        le_cnt[i] = le_cnt[i] + 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (!found && (i < int'(win_len)) && (int'(lt_cnt[i]) <= int'(half_reg))
                && (int'(le_cnt[i]) > int'(half_reg))) begin
                median = window_reg[i];
                found  = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Emit side: main word first, then flush words, one per free slot.
    // ------------------------------------------------------------------
    assign pend_any = main_reg || (flush_reg != '0);
    assign advance  = pend_any && (!m_valid_reg || m_tready);

    // take a word only when all pending work is gone after this edge
    always_comb begin
        if (!pend_any) begin
            s_tready = 1'b1;
        end else if (advance) begin
            s_tready = main_reg ? (flush_reg == '0) : (flush_reg == HALF_BITS'(1));
        end else begin
            s_tready = 1'b0;
        end
    end

    logic signed [SAMPLE_BITS-1:0] emit_sample;
    logic                          emit_filt;
    logic                          emit_last;

    always_comb begin
        if (main_reg) begin
            emit_sample = main_med_reg ? median : window_reg[main_idx_reg];
            emit_filt   = main_med_reg;
            emit_last   = main_last_reg;
        end else begin
            emit_sample = window_reg[IDXW'(flush_reg - 1'b1)];
            emit_filt   = 1'b0;
            emit_last   = (flush_reg == HALF_BITS'(1));
        end
    end

    // ------------------------------------------------------------------
    // Accept side: run settings, position count and the new pending work.
    // ------------------------------------------------------------------
    always_comb begin
        logic          start_run;
        logic [CW-1:0] pc_inc;
        logic          has_main;

        start_run = (count_reg == '0);
        filt_next = filt_reg;
        half_next = half_reg;
        count_next     = count_reg;
        main_next      = main_reg;
        main_med_next  = main_med_reg;
        main_idx_next  = main_idx_reg;
        main_last_next = main_last_reg;
        flush_next     = flush_reg;
        pc_inc         = count_reg;
        has_main       = 1'b0;

        // drain what the output register takes this cycle
        if (advance) begin
            if (main_reg) begin
                main_next = 1'b0;
            end else begin
                flush_next = flush_reg - 1'b1;
            end
        end

        if (s_accept) begin
            if (start_run) begin
                filt_next = ws_reg[0] && (int'(ws_reg) <= MAX_WINDOW);
                half_next = ws_reg[CFG_BITS-1:1];
            end
            pc_inc     = (count_reg < CNT_MAX) ? (count_reg + 1'b1) : count_reg;
            count_next = s_tlast ? '0 : pc_inc;

            if (!filt_next) begin
                // pass-through: newest sample at once
                main_next      = 1'b1;
                main_med_next  = 1'b0;
                main_idx_next  = '0;
                main_last_next = s_tlast;
                flush_next     = '0;
            end else begin
                has_main       = int'(pc_inc) > int'(half_next);
                main_next      = has_main;
                main_med_next  = int'(pc_inc) >= (2 * int'(half_next) + 1);
                main_idx_next  = IDXW'(half_next);
                main_last_next = s_tlast && (half_next == '0);
                if (s_tlast) begin
                    flush_next = has_main ? half_next : HALF_BITS'(pc_inc);
                end else begin
                    flush_next = '0;
                end
            end
        end
    end

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            half_reg    <= HALF_BITS'(CFG_RESET >> 1);
            filt_reg    <= 1'b1;
            ws_reg      <= CFG_RESET;
            main_reg    <= 1'b0;
            flush_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            half_reg    <= half_next;
            filt_reg    <= filt_next;
            main_reg    <= main_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                ws_reg <= cfg_data;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        main_med_reg  <= main_med_next;
        main_idx_reg  <= main_idx_next;
        main_last_reg <= main_last_next;
        if (s_accept) begin
            window_reg[0] <= s_tdata[SAMPLE_BITS-1:0];
            for (int d = 1; d < MAX_WINDOW; d++) begin
                window_reg[d] <= window_reg[d-1];
            end
        end
        if (advance) begin
            out_sample_reg <= emit_sample;
            out_filt_reg   <= emit_filt;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_BITS'($unsigned(out_sample_reg));
    assign m_tuser  = out_filt_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a last word always closes the run
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> count_reg == '0)
        else $error("position count not cleared after last word");

    // run settings only change at the start of a waveform
    a_run_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |=> $stable(half_reg) && $stable(filt_reg))
        else $error("run settings changed inside a waveform");

    // no input while more than one flush word is left
    a_flush_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg > HALF_BITS'(1) |-> !s_tready)
        else $error("input taken during flush");

    // count saturates at the store depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("position count overflow");
`endif

endmodule : sliding_median_filter

`default_nettype wire

FILE: sim/testbench.sv
// Stream testbench for the sliding median filter: directed and random waveforms, scoreboard check.
`timescale 1ns / 1ps

module testbench;
    import smf_pkg::*;

    localparam int MAX_WINDOW  = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SETTLE      = 24;      // flush of the widest window plus pipeline slack
    localparam int HOLD_CYCLES = 80;      // long receiver hold-off
    localparam int LIMIT       = 300000;  // watchdog, in clock cycles
    localparam int PHASE_WORDS = 1;       // minimum input words per random phase

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        sample_t value;
        logic    filtered;
        logic    last;
    } median_word_t;

    typedef enum int {RX_OPEN, RX_SKIP_THIRD, RX_COIN, RX_TRICKLE} rx_pattern_t;
    typedef enum int {DATA_FULL, DATA_TIES, DATA_CORNERS, DATA_NARROW} data_shape_t;

    // Tracks the filter state and queues the words it must emit.
    class filter_book;
        sample_t                taps[MAX_WINDOW];
        int                     depth_seen;
        logic [CFG_BITS-1:0]    win_len;
        int                     half;
        bit                     filtering;
        median_word_t           awaited_words[$];
        int                     errors;

        function new();
            depth_seen = 0;
            win_len    = CFG_RESET;
            half       = 1;
            filtering  = 1'b1;
            errors     = 0;
        endfunction

        function void set_window(logic [CFG_BITS-1:0] v);
            win_len = v;
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        // Value whose rank is the middle of taps[0 .. 2h].
        function sample_t median_of_taps(int h);
            int      w;
            int      below;
            int      not_above;
            sample_t pick;
            w    = 2 * h + 1;
            pick = taps[0];
            for (int i = 0; i < w; i++) begin
                below     = 0;
                not_above = 0;
                for (int j = 0; j < w; j++) begin
                    if (taps[j] < taps[i])  below++;
                    if (taps[j] <= taps[i]) not_above++;
                end
                if (below <= h && not_above > h) pick = taps[i];
            end
            return pick;
        endfunction

        function void push_word(sample_t v, logic f, logic l);
            median_word_t w;
            w.value    = v;
            w.filtered = f;
            w.last     = l;
            awaited_words.push_back(w);
        endfunction

        // Accepted input word: advance the window and queue what it releases.
        function void note_sample(sample_t x, logic lst);
            int first_flush;
            // window is latched at the first sample of a waveform
            if (depth_seen == 0) begin
                filtering = win_len[0] && (win_len <= MAX_WINDOW);
                half      = win_len / 2;
            end
            for (int d = MAX_WINDOW - 1; d > 0; d--) taps[d] = taps[d-1];
            taps[0] = x;
            if (depth_seen < MAX_WINDOW) depth_seen++;

            if (!filtering) begin
                push_word(x, 1'b0, lst);
                if (lst) depth_seen = 0;
                return;
            end

            if (depth_seen > half) begin
                if (depth_seen >= 2 * half + 1)
                    push_word(median_of_taps(half), 1'b1, lst && half == 0);
                else
                    push_word(taps[half], 1'b0, lst && half == 0);
            end

            if (lst) begin
                first_flush = (depth_seen > half) ? half : depth_seen;
                for (int d = first_flush; d > 0; d--)
                    push_word(taps[d-1], 1'b0, d == 1);
                depth_seen = 0;
            end
        endfunction

        task report_mismatch(string what);
            if (errors < 40) $display("%0t: mismatch: %s", $time, what);
            errors++;
        endtask

        task check_word(sample_t v, logic f, logic l);
            median_word_t w;
            if (awaited_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d user %b last %b", v, f, l));
                return;
            end
            w = awaited_words.pop_front();
            if (v !== w.value)
                report_mismatch($sformatf("sample %0d, want %0d", v, w.value));
            if (f !== w.filtered)
                report_mismatch($sformatf("filtered flag %b, want %b (sample %0d)",
                                          f, w.filtered, w.value));
            if (l !== w.last)
                report_mismatch($sformatf("last flag %b, want %b (sample %0d)",
                                          l, w.last, w.value));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata   = '0;     // [SAMPLE_BITS-1:0] sample_in
    logic                 s_tlast   = 1'b0;   // last_in
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_BITS-1:0] m_tdata;            // [SAMPLE_BITS-1:0] sample_out
    logic                 m_tuser;            // was_filtered
    logic                 m_tlast;            // last_out
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_BITS-1:0]  cfg_data  = '0;     // window_size

    filter_book  book;
    int unsigned cycle_count = 0;
    bit          gaps_on     = 1'b1;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;
    int          hold_count  = 0;
    int          pat_count   = 0;
    rx_pattern_t rx_mode     = RX_OPEN;

    sliding_median_filter #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count++;

    // Both handshakes are observed in one process, so an input word is always
    // booked before any output word of the same edge is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                book.note_sample(sample_t'(s_tdata[SAMPLE_BITS-1:0]), s_tlast);
            if (m_tvalid && m_tready)
                book.check_word(sample_t'(m_tdata[SAMPLE_BITS-1:0]), m_tuser, m_tlast);
        end
    end

    // Receiver: a long hold-off on request, otherwise a changing stall pattern.
    always @(negedge aclk) begin
        if (hold_req) begin
            m_tready = 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_req   = 1'b0;
                hold_count = 0;
            end
        end else begin
            pat_count++;
            if (pat_count % 50 == 0) rx_mode = rx_pattern_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:       m_tready = 1'b1;
                RX_SKIP_THIRD: m_tready = (pat_count % 3) != 0;
                RX_COIN:       m_tready = 1'($urandom_range(0, 1));
                default:       m_tready = (pat_count % 4) == 0;
            endcase
        end
    end

    initial begin : watchdog
        wait (cycle_count >= LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_word(input sample_t smp, input bit lst);
        s_tdata  = DATA_BITS'(smp);
        s_tlast  = lst;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_run(input sample_t vals[$], input bit close);
        foreach (vals[i]) send_word(vals[i], close && i == vals.size() - 1);
    endtask

    // Sender pause: every awaited word back, then room for a trailing flush.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_window(input logic [CFG_BITS-1:0] v);
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        book.set_window(v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic sample_t pick_sample(data_shape_t shape);
        sample_t corners[5];
        corners = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001};
        case (shape)
            DATA_FULL:    return sample_t'($urandom());
            DATA_TIES:    return sample_t'(int'($urandom_range(0, 8)) - 4);
            DATA_CORNERS: return corners[$urandom_range(0, 4)];
            default:      return sample_t'(int'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    // One whole waveform with last on its final word; returns its length.
    task automatic send_waveform(input int win, input int max_len, output int len);
        data_shape_t shape;
        shape = data_shape_t'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 2 || win < 2)
            len = $urandom_range(1, (win < 2) ? 6 : win);   // up to the window length; 1 to 6 for windows under 2
        else
            len = $urandom_range(win + 1, win + 4);
        if (len > max_len) len = max_len;
        for (int i = 0; i < len; i++) send_word(pick_sample(shape), i == len - 1);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : main
        int win_list[9];
        int phase_words;
        int len;

        win_list = '{5, 15, 0, 7, 2, 9, 13, 1, 3};
        book = new();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed, reset window of 3: field extremes, a median over both ends
        // of the range, waveforms shorter than the window, and equal samples.
        gaps_on = 1'b0;
        send_run('{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff, 16'shffff}, 1'b1);
        send_run('{16'sh1234}, 1'b1);
        send_run('{-16'sd7, 16'sd7}, 1'b1);
        gaps_on = 1'b1;
        send_run('{16'sd5, 16'sd5, -16'sd3, 16'sd5}, 1'b1);
        wait_drained();

        // Zero window passes through.
        write_window(4'd0);
        send_run('{16'sh5555, 16'shaaaa}, 1'b1);
        wait_drained();

        // Window of one: each sample is its own median. The change to 5 lands
        // mid-waveform and must wait for the next waveform.
        write_window(4'd1);
        send_run('{16'sh00ff, -16'sd300}, 1'b0);
        wait_drained();
        write_window(4'd5);
        send_run('{16'sd42}, 1'b1);
        send_run('{16'sd9, 16'sd1, 16'sd8, 16'sd2, 16'sd7, 16'sd3}, 1'b1);
        wait_drained();

        // Random phases over a spread of window settings.
        foreach (win_list[p]) begin
            write_window(CFG_BITS'(win_list[p]));
            gaps_on     = ($urandom_range(0, 3) != 0);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                send_waveform(win_list[p], 24, len);
                phase_words += len;
            end
            wait_drained();
        end

        // Backpressure: widest window, receiver held off, sender keeps offering.
        write_window(4'd15);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) send_word(pick_sample(DATA_FULL), i == 23);
        gaps_on = 1'b1;

        s_tvalid = 1'b0;
        for (int i = 0; i < 5000 && book.pending() != 0; i++) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (book.pending() != 0)
            book.report_mismatch($sformatf("%0d words never arrived", book.pending()));

        if (book.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
